>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker files. Each macro takes a label,
// a condition and an expected consequence. All use clk, and are disabled
// while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequence holds in the same cycle as the condition.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");

// Consequence holds in the cycle after the condition.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");

`endif

>>> rtl/msm_pkg.sv
// ---------------------------------------------------------------------------
// msm_pkg
// Types, constants and helpers shared by the string matcher modules.
// ---------------------------------------------------------------------------
package msm_pkg;

  localparam int MAX_PATTERN_LEN = 8;
  localparam int NUM_PATTERNS    = 4;
  localparam int PAT_W           = 8 * MAX_PATTERN_LEN;
  localparam int LEN_W           = 4;
  localparam int MODE_W          = 3;
  localparam int CNT_W           = 16;
  localparam int CFG_IDX_W       = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PAT0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODES   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTHS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NEGATE  = 3'd6;

  // Per-slot match modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_SUBSTR = 3'd0,
    MODE_PREFIX = 3'd1,
    MODE_EXACT  = 3'd2,
    MODE_SUFFIX = 3'd3,
    MODE_ALWAYS = 3'd4
  } mode_t;

  // Settings of one slot as seen by the slot logic.
  typedef struct packed {
    logic [PAT_W-1:0] pattern;  // folded to lower case
    logic [LEN_W-1:0] len;      // clamped to 0..MAX_PATTERN_LEN
    logic [MODE_W-1:0] mode;
  } slot_cfg_t;

  // Per-slot status produced for one byte.
  typedef struct packed {
    logic hit_next;    // pattern seen somewhere so far
    logic good_next;   // string opening still agrees with pattern
    logic match;       // slot verdict if this byte ends the string
  } slot_stat_t;

  // Map ASCII A..Z onto a..z, leave every other byte alone.
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  function automatic logic [PAT_W-1:0] fold_word(input logic [PAT_W-1:0] w);
    logic [PAT_W-1:0] r;
    for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
      r[8*k +: 8] = fold_byte(w[8*k +: 8]);
    end
    return r;
  endfunction

endpackage

>>> rtl/multi_pattern_string_matcher_core.sv
// ---------------------------------------------------------------------------
// multi_pattern_string_matcher_core
// Case-insensitive matcher of a byte stream against four alternatives.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one string byte per item in s_tdata[7:0], s_tlast
//   marks the final byte of a string. Every string carries at least one byte.
//   Output stream (m_*): one item per string, sent after its final byte;
//   m_tdata[0] is the verdict (any listed slot matched, xor negate).
//   Config port (cfg_*): write pattern, mode, length and negate registers by
//   index; always ready. Write only while no string is in flight.
// Timing:
//   One byte per cycle while s_tready is high. The verdict is in the
//   output register in the cycle after the final byte is taken. The
//   whole per-byte update (window shift, four tail compares, flags) is one
//   level of logic between the state registers and the result register.
// Reset and stall:
//   rst clears the configuration and string state and empties the output
//   register. While the output holds an unclaimed verdict and m_tready is
//   low, s_tready drops; it stays high whenever the output register is empty
//   or being drained in that cycle.
// ---------------------------------------------------------------------------
module multi_pattern_string_matcher_core
  import msm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input byte stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] char_byte
  input  logic                 s_tlast,   // last_byte
  // verdict stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [0] verdict, [7:1] zero
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_data
);

  // Configuration registers; patterns held already folded.
  logic [PAT_W-1:0]               pattern [NUM_PATTERNS];
  logic [MODE_W*NUM_PATTERNS-1:0] modes;
  logic [LEN_W*NUM_PATTERNS-1:0]  lengths;
  logic                           negate;

  // String state.
  logic [PAT_W-1:0]        window;
  logic [CNT_W-1:0]        count;
  logic [NUM_PATTERNS-1:0] hits;
  logic [NUM_PATTERNS-1:0] good;

  logic [PAT_W-1:0]        window_next;
  logic [CNT_W-1:0]        count_next;
  logic [NUM_PATTERNS-1:0] hits_next;
  logic [NUM_PATTERNS-1:0] good_next;
  logic [NUM_PATTERNS-1:0] slot_match;
  logic [NUM_PATTERNS-1:0] slot_live;
  logic                    verdict_next;
  logic                    in_accept;

  slot_cfg_t  slot_cfg  [NUM_PATTERNS];
  slot_stat_t slot_stat [NUM_PATTERNS];

  assign cfg_ready = 1'b1;
  assign s_tready  = ~m_tvalid | m_tready;
  assign in_accept = s_tvalid & s_tready;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_PATTERNS; s++) begin
        pattern[s] <= '0;
      end
      modes   <= '0;
      lengths <= '0;
      negate  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PAT0:    pattern[0] <= fold_word(cfg_data);
        REG_PAT1:    pattern[1] <= fold_word(cfg_data);
        REG_PAT2:    pattern[2] <= fold_word(cfg_data);
        REG_PAT3:    pattern[3] <= fold_word(cfg_data);
        REG_MODES:   modes      <= cfg_data[MODE_W*NUM_PATTERNS-1:0];
        REG_LENGTHS: lengths    <= cfg_data[LEN_W*NUM_PATTERNS-1:0];
        REG_NEGATE:  negate     <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // Shift the folded byte into the top of the window, advance the count.
  assign window_next = {fold_byte(s_tdata), window[PAT_W-1:8]};
  assign count_next  = (count == '1) ? count : count + 16'd1;

  genvar g;
  generate
    for (g = 0; g < NUM_PATTERNS; g++) begin : g_slot
      logic [LEN_W-1:0] raw_len;
      assign raw_len = lengths[LEN_W*g +: LEN_W];
      assign slot_cfg[g].pattern = pattern[g];
      assign slot_cfg[g].len     = (raw_len > LEN_W'(MAX_PATTERN_LEN)) ?
                                   LEN_W'(MAX_PATTERN_LEN) : raw_len;
      assign slot_cfg[g].mode    = modes[MODE_W*g +: MODE_W];

      msm_slot u_slot (
        .cfg         (slot_cfg[g]),
        .window_next (window_next),
        .count_next  (count_next),
        .hit         (hits[g]),
        .good        (good[g]),
        .stat        (slot_stat[g])
      );

      assign hits_next[g]  = slot_stat[g].hit_next;
      assign good_next[g]  = slot_stat[g].good_next;
      assign slot_match[g] = slot_stat[g].match;

      // A zero-length slot ends the list: it and all later slots drop out.
      if (g == 0) begin : g_first
        assign slot_live[g] = (raw_len != '0);
      end else begin : g_rest
        assign slot_live[g] = slot_live[g-1] & (raw_len != '0);
      end
    end
  endgenerate

  assign verdict_next = (|(slot_match & slot_live)) ^ negate;

  // String state: advance on each byte, return to reset after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      count  <= '0;
      hits   <= '0;
      good   <= '1;
    end else if (in_accept) begin
      if (s_tlast) begin
        window <= '0;
        count  <= '0;
        hits   <= '0;
        good   <= '1;
      end else begin
        window <= window_next;
        count  <= count_next;
        hits   <= hits_next;
        good   <= good_next;
      end
    end
  end

  // Output register: load on a final byte, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && s_tlast) begin
      m_tdata <= {7'b0, verdict_next};
    end
  end

endmodule

>>> rtl/msm_slot.sv
// ---------------------------------------------------------------------------
// msm_slot
// Match logic of one pattern slot: tail compare against the byte window,
// running substring and prefix flags, and the slot verdict per mode.
// ---------------------------------------------------------------------------
module msm_slot
  import msm_pkg::*;
(
  input  slot_cfg_t        cfg,
  input  logic [PAT_W-1:0] window_next,  // includes the current byte on top
  input  logic [CNT_W-1:0] count_next,   // bytes of the string incl. this one
  input  logic             hit,
  input  logic             good,
  output slot_stat_t       stat
);

  logic [PAT_W-1:0] tail;
  logic [PAT_W-1:0] mask;
  logic [5:0]       shamt;
  logic             tail_eq;
  logic             active;
  logic             enough;
  logic [2:0]       pos;
  logic [7:0]       cur_byte;
  logic [CNT_W-1:0] len_ext;

  assign len_ext  = CNT_W'(cfg.len);
  assign active   = (cfg.len != '0);
  assign enough   = (count_next >= len_ext);
  assign cur_byte = window_next[PAT_W-1 -: 8];

  // Last len bytes of the window, oldest byte lowest.
  assign shamt = {3'(4'(MAX_PATTERN_LEN) - cfg.len), 3'b000};
  assign tail  = window_next >> shamt;

  always_comb begin
    for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
      mask[8*j +: 8] = (LEN_W'(j) < cfg.len) ? 8'hFF : 8'h00;
    end
  end

  assign tail_eq = (((tail ^ cfg.pattern) & mask) == '0);

  // Position of this byte inside the string opening.
  assign pos = 3'(count_next - 16'd1);

  always_comb begin
    stat.hit_next  = hit | (active & enough & tail_eq);
    stat.good_next = good;
    if (active && (count_next <= len_ext) && (cfg.pattern[8*pos +: 8] != cur_byte)) begin
      stat.good_next = 1'b0;
    end
    case (cfg.mode)
      MODE_SUBSTR: stat.match = enough & stat.hit_next;
      MODE_PREFIX: stat.match = enough & stat.good_next;
      MODE_EXACT:  stat.match = (count_next == len_ext) & tail_eq;
      MODE_SUFFIX: stat.match = enough & tail_eq;
      MODE_ALWAYS: stat.match = 1'b1;
      default:     stat.match = 1'b0;
    endcase
  end

endmodule

>>> rtl/msm_checker.sv
// ---------------------------------------------------------------------------
// msm_checker
// Port-level checks on the string matcher, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module msm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // A stalled verdict holds.
  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // A final byte always yields a verdict next cycle.
  `ASSERT_NEXT(a_last_gives_out, s_tvalid && s_tready && s_tlast, m_tvalid)

  // A non-final byte into an empty output gives no verdict.
  `ASSERT_NEXT(a_no_spurious, s_tvalid && s_tready && !s_tlast && !m_tvalid, !m_tvalid)

  // Input is never blocked while the output register is empty.
  `ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready)

  // Padding bits of the verdict stay zero.
  `ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[7:1] == 7'd0)

endmodule

bind multi_pattern_string_matcher_core msm_checker u_msm_checker (.*);

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the multi-pattern string matcher core
// Streams strings one byte per item into the matcher and predicts each
// verdict with an independent model of the window, length count and
// per-slot flags. Register settings change between groups of strings, and
// both stream sides idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import msm_pkg::*;

  localparam int RUN_LIMIT_NS = 5_000_000;

  // Predicts the verdict of every completed string and compares it against
  // the verdict items leaving the block.
  class verdict_scoreboard;
    logic [PAT_W-1:0]               pat_reg [NUM_PATTERNS];
    logic [MODE_W*NUM_PATTERNS-1:0] mode_reg;
    logic [LEN_W*NUM_PATTERNS-1:0]  len_reg;
    logic                           neg_reg;
    logic [PAT_W-1:0]               window;     // newest byte on top
    logic [CNT_W-1:0]               seen;
    logic [NUM_PATTERNS-1:0]        hits;
    logic [NUM_PATTERNS-1:0]        good;
    logic                           expected_verdicts [$];
    int                             errors;
    int                             checked;

    function new();
      foreach (pat_reg[s]) pat_reg[s] = '0;
      mode_reg = '0;
      len_reg  = '0;
      neg_reg  = 1'b0;
      errors   = 0;
      checked  = 0;
      restart();
    endfunction

    function void restart();
      window = '0;
      seen   = '0;
      hits   = '0;
      good   = '1;
    endfunction

    function logic [7:0] lower_case(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function int slot_length(int s);
      int l;
      l = int'(len_reg[LEN_W*s +: LEN_W]);
      return (l > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : l;
    endfunction

    // Compare the newest l bytes of the window with the slot's pattern.
    function bit window_ends_with(int s, int l);
      logic [PAT_W-1:0] tail;
      tail = window >> (8 * (MAX_PATTERN_LEN - l));
      for (int k = 0; k < l; k++) begin
        if (tail[8*k +: 8] != lower_case(pat_reg[s][8*k +: 8])) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [PAT_W-1:0] val);
      case (idx)
        REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: pat_reg[idx[1:0]] = val;
        REG_MODES:   mode_reg = val[MODE_W*NUM_PATTERNS-1:0];
        REG_LENGTHS: len_reg  = val[LEN_W*NUM_PATTERNS-1:0];
        REG_NEGATE:  neg_reg  = val[0];
        default: ;
      endcase
    endfunction

    // Note one accepted string byte; on the final byte queue the verdict.
    function void note_byte(logic [7:0] raw, logic last);
      logic [7:0] c;
      int         l;
      int         pos;
      bit         any;
      bit         enough;
      c      = lower_case(raw);
      window = {c, window[PAT_W-1:8]};
      if (seen != '1) seen++;
      for (int s = 0; s < NUM_PATTERNS; s++) begin
        l = slot_length(s);
        if (l == 0) continue;
        if (seen >= l && window_ends_with(s, l)) hits[s] = 1'b1;
        if (seen <= l) begin
          pos = (int'(seen) - 1) & 7;
          if (lower_case(pat_reg[s][8*pos +: 8]) != c) good[s] = 1'b0;
        end
      end
      if (!last) return;
      any = 1'b0;
      for (int s = 0; s < NUM_PATTERNS && !any; s++) begin
        l = slot_length(s);
        if (l == 0) break;             // an empty slot ends the list
        enough = (seen >= l);
        case (mode_t'(mode_reg[MODE_W*s +: MODE_W]))
          MODE_SUBSTR: any = enough && hits[s];
          MODE_PREFIX: any = enough && good[s];
          MODE_EXACT:  any = (seen == l) && window_ends_with(s, l);
          MODE_SUFFIX: any = enough && window_ends_with(s, l);
          MODE_ALWAYS: any = 1'b1;
          default:     any = 1'b0;     // unknown codes never match
        endcase
      end
      expected_verdicts.push_back(any ^ neg_reg);
      restart();
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    task report(string what);
      $display("%0t  MISMATCH  %s", $time, what);
      errors++;
    endtask

    task check_verdict(logic [7:0] data);
      logic want;
      if (expected_verdicts.size() == 0) begin
        report($sformatf("verdict %0d arrived with no string completed", data[0]));
      end else begin
        want = expected_verdicts.pop_front();
        checked++;
        if (data[0] !== want) begin
          report($sformatf("verdict %0d, expected %0d", data[0], want));
        end
        if (data[7:1] !== 7'd0) begin
          report($sformatf("padding bits 0x%0h not zero", data[7:1]));
        end
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;   // [7:0] char_byte
  logic                 s_tlast;   // last_byte
  logic                 m_tvalid;
  logic                 m_tready;
  logic [7:0]           m_tdata;   // [0] verdict, [7:1] zero
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAT_W-1:0]     cfg_data;

  verdict_scoreboard sb = new();

  int               send_idle_pct = 0;
  int               stall_pct     = 0;
  int               bytes_sent    = 0;
  int               strings_sent  = 0;
  int               writes_done   = 0;
  logic [PAT_W-1:0] cur_pat [NUM_PATTERNS];
  int               cur_len [NUM_PATTERNS];
  logic [7:0]       text_q [$];

  multi_pattern_string_matcher_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #RUN_LIMIT_NS;
    $display("simulation failed");
    $finish;
  end

  // Receiver: drop tready at random according to the current phase.
  initial begin
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Observe every handshake at the clock edge, before any driver update lands.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_verdict(m_tdata);
    end
  end

  // Mostly letters a..c in either case so that patterns hit often; the rest
  // zero bytes and arbitrary bytes.
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0:       c = 8'h00;
      1, 2:    c = 8'($urandom_range(0, 255));
      default: begin
        c = 8'h61 + 8'($urandom_range(0, 2));
        if ($urandom_range(0, 1) == 1) c = c ^ 8'h20;
      end
    endcase
    return c;
  endfunction

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    writes_done++;
  endtask

  // Offer one item, with random idle cycles ahead of it, and hold until taken.
  task automatic push_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) push_byte(text_q[i], i == text_q.size() - 1);
    strings_sent++;
  endtask

  // Wait until every verdict is back, with the input stream idle.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic randomize_settings();
    logic [MODE_W*NUM_PATTERNS-1:0] modes;
    logic [LEN_W*NUM_PATTERNS-1:0]  lens;
    int                             r;
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      for (int k = 0; k < MAX_PATTERN_LEN; k++) cur_pat[s][8*k +: 8] = pick_char();
      r = $urandom_range(0, 19);
      if (r == 0) cur_len[s] = 0;
      else if (r == 1) cur_len[s] = $urandom_range(9, 15);
      else if (r < 14) cur_len[s] = $urandom_range(1, 3);
      else cur_len[s] = $urandom_range(4, 8);
      lens[LEN_W*s +: LEN_W] = LEN_W'(cur_len[s]);
      modes[MODE_W*s +: MODE_W] = ($urandom_range(0, 9) == 0) ?
                                  MODE_W'($urandom_range(5, 7)) :
                                  MODE_W'($urandom_range(0, 4));
      write_reg(REG_PAT0 + CFG_IDX_W'(s), cur_pat[s]);
    end
    write_reg(REG_MODES, PAT_W'(modes));
    write_reg(REG_LENGTHS, PAT_W'(lens));
    write_reg(REG_NEGATE, PAT_W'($urandom_range(0, 3) == 0));
    cfg_valid <= 1'b0;
  endtask

  // Build a string around a copy of one slot's pattern in random case, with
  // random padding on either side; some copies are damaged, some left out.
  task automatic build_text();
    int         s;
    int         l;
    int         pad;
    logic [7:0] c;
    logic [7:0] lc;
    text_q.delete();
    if ($urandom_range(0, 29) == 0) pad = $urandom_range(9, 40);
    else if ($urandom_range(0, 3) == 0) pad = 0;
    else pad = $urandom_range(1, 4);
    repeat (pad) text_q.push_back(pick_char());
    if ($urandom_range(0, 3) != 0) begin
      s = $urandom_range(0, NUM_PATTERNS - 1);
      l = (cur_len[s] > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : cur_len[s];
      for (int k = 0; k < l; k++) begin
        c  = cur_pat[s][8*k +: 8];
        lc = c | 8'h20;
        if (lc >= 8'h61 && lc <= 8'h7A && $urandom_range(0, 1) == 1) c = c ^ 8'h20;
        if ($urandom_range(0, 11) == 0) c = pick_char();
        text_q.push_back(c);
      end
    end
    pad = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
    repeat (pad) text_q.push_back(pick_char());
    if (text_q.size() == 0) text_q.push_back(pick_char());
  endtask

  initial begin
    int idle_pcts  [4] = '{0, 69, 0, 28};
    int stall_pcts [4] = '{0, 0, 69, 28};
    int round_end;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: empty list, a single zero byte.
    text_q = '{8'h00};
    send_text();
    drain();

    // One slot per mode except always, a long length, non-letter boundaries.
    write_reg(REG_PAT0, 64'h6261);                 // "ab"
    write_reg(REG_PAT1, '1);                       // eight 0xff bytes
    write_reg(REG_PAT2, 64'h7A00);                 // zero byte, 'z'
    write_reg(REG_PAT3, 64'h405B);                 // "[@"
    write_reg(REG_MODES, PAT_W'({MODE_SUFFIX, MODE_EXACT, MODE_PREFIX, MODE_SUBSTR}));
    write_reg(REG_LENGTHS, 64'h22F2);
    write_reg(REG_NEGATE, 64'h0);
    cfg_valid <= 1'b0;
    text_q = '{8'h78, 8'h41, 8'h42};               // substring in upper case
    send_text();
    text_q.delete();
    repeat (8) text_q.push_back(8'hFF);            // prefix of clamped length
    send_text();
    text_q = '{8'h00, 8'h5A};                      // exact with a zero byte
    send_text();
    text_q = '{8'h78, 8'h5B, 8'h40};               // suffix
    send_text();
    text_q = '{8'h61};                             // shorter than every slot
    send_text();
    drain();

    // Unknown modes everywhere, inverted verdict, zero patterns.
    write_reg(REG_PAT0, '0);
    write_reg(REG_PAT1, '0);
    write_reg(REG_PAT2, '0);
    write_reg(REG_PAT3, '0);
    write_reg(REG_MODES, 64'hFFF);
    write_reg(REG_LENGTHS, 64'hFFFF);
    write_reg(REG_NEGATE, 64'h1);
    cfg_valid <= 1'b0;
    text_q = '{8'h00};
    send_text();
    drain();

    // Empty first slot hides an always-match slot behind it.
    write_reg(REG_MODES, PAT_W'({MODE_SUBSTR, MODE_SUBSTR, MODE_ALWAYS, MODE_SUBSTR}));
    write_reg(REG_LENGTHS, 64'h0010);
    write_reg(REG_NEGATE, 64'h0);
    cfg_valid <= 1'b0;
    text_q = '{8'h5A};
    send_text();
    drain();

    // Always-match on a string shorter than the slot length.
    write_reg(REG_MODES, PAT_W'({MODE_SUBSTR, MODE_SUBSTR, MODE_SUBSTR, MODE_ALWAYS}));
    write_reg(REG_LENGTHS, 64'h0005);
    cfg_valid <= 1'b0;
    text_q = '{8'h41};
    send_text();

    // Random strings under fresh settings, phase by phase.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_pcts[ph];
      stall_pct     = stall_pcts[ph];
      repeat (8) begin
        drain();
        randomize_settings();
        round_end = bytes_sent + 48;
        while (bytes_sent < round_end) begin
          build_text();
          send_text();
        end
      end
    end

    // One string far longer than the window, ending in "xYz".
    send_idle_pct = 0;
    stall_pct     = 0;
    drain();
    write_reg(REG_PAT0, 64'h7A7978);
    write_reg(REG_PAT1, 64'h7A7978);
    write_reg(REG_MODES, PAT_W'({MODE_SUBSTR, MODE_SUBSTR, MODE_SUFFIX, MODE_EXACT}));
    write_reg(REG_LENGTHS, 64'h0033);
    cfg_valid <= 1'b0;
    text_q.delete();
    repeat (60) text_q.push_back(pick_char());
    text_q.push_back(8'h78);
    text_q.push_back(8'h59);
    text_q.push_back(8'h7A);
    send_text();
    drain();

    $display("Run covered %0d bytes in %0d strings with %0d register writes.",
             bytes_sent, strings_sent, writes_done);
    $display("%0d verdicts compared, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
